/* rtl/core/carc_pkg.sv */
// Package for the card access rule check unit: opcodes, verdicts, the command
// and result records, and the default sizes.
// No dependencies; every other file of the unit imports it.
`timescale 1ns / 1ps

package carc_pkg;

    // Default sizes
    localparam int MAX_RECORDS_DEF = 256;
    localparam int UID_BYTES_DEF   = 10;

    // Field widths
    localparam int UID_MAX_BYTES = 10;
    localparam int UID_MAX_W     = 8 * UID_MAX_BYTES;
    localparam int UID_LOW_W     = 64;
    localparam int UID_HIGH_W    = 16;
    localparam int LEN_W         = 4;
    localparam int STAMP_W       = 32;
    localparam int FLOOR_W       = 32;
    localparam int MIN_W         = 11;
    localparam int HOUR_W        = 5;
    localparam int MINUTE_W      = 6;
    localparam int COUNT_W       = 9;
    localparam int SEL_W         = 5;

    localparam logic [MIN_W-1:0] DAY_MINUTES  = 11'd1440;
    localparam logic [MIN_W-1:0] HOUR_MINUTES = 11'd60;

    // Command queue between front and back
    localparam int CMD_FIFO_DEPTH = 4;

    // Configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic REG_FLOOR_SELECT = 1'b0;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_EVAL   = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        V_UNKNOWN  = 2'd0,
        V_EXPIRED  = 2'd1,
        V_SCHEDULE = 2'd2,
        V_GRANTED  = 2'd3
    } verdict_t;

    typedef enum logic {
        BK_IDLE,
        BK_SCAN
    } bk_state_t;

    // One classified request as it travels from front to back.
    // stamp is the expiry for an append and the current time for an evaluate.
    typedef struct packed {
        op_t                    kind;
        logic [UID_MAX_W-1:0]   uid;
        logic [UID_MAX_W-1:0]   mask;
        logic [LEN_W-1:0]       len;
        logic [STAMP_W-1:0]     stamp;
        logic [FLOOR_W-1:0]     floors;
        logic [MIN_W-1:0]       win_start;
        logic [MIN_W-1:0]       win_end;
        logic [MIN_W-1:0]       minute;
    } cmd_t;

    typedef struct packed {
        verdict_t               verdict;
        logic                   stored;
        logic [COUNT_W-1:0]     count;
    } res_t;

endpackage

/* rtl/core/carc_front.sv */
// Front stage of the card access rule check unit: takes input requests,
// classifies them and precomputes the UID compare mask and minute of day.
// Depends on carc_pkg.
`timescale 1ns / 1ps

module carc_front import carc_pkg::*; #(
    parameter int UID_BYTES = UID_BYTES_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    output logic                    full,
    input  logic [1:0]              opcode,
    input  logic [UID_LOW_W-1:0]    uid_low,
    input  logic [UID_HIGH_W-1:0]   uid_high,
    input  logic [LEN_W-1:0]        uid_length,
    input  logic [STAMP_W-1:0]      valid_until,
    input  logic [FLOOR_W-1:0]      floor_bits,
    input  logic [MIN_W-1:0]        window_start,
    input  logic [MIN_W-1:0]        window_end,
    input  logic [STAMP_W-1:0]      now_seconds,
    input  logic [HOUR_W-1:0]       now_hour,
    input  logic [MINUTE_W-1:0]     now_minute,
    output logic                    cmd_valid,
    output cmd_t                    cmd,
    input  logic                    cmd_ready
);

    logic               valid_reg;
    logic               valid_next;
    cmd_t               cmd_reg;
    cmd_t               cmd_next;
    logic               accept;
    logic [LEN_W-1:0]   cmp_len;

    assign full   = valid_reg && !cmd_ready;
    assign accept = push && !full;

    // Bytes that take part in the compare: the length, capped at the UID size
    assign cmp_len = (uid_length > LEN_W'(UID_BYTES)) ? LEN_W'(UID_BYTES) : uid_length;

    always_comb
    begin
        cmd_next.kind  = op_t'(opcode);
        cmd_next.uid   = {uid_high, uid_low};
        cmd_next.len   = uid_length;
        cmd_next.stamp = (op_t'(opcode) == OP_EVAL) ? now_seconds : valid_until;
        cmd_next.floors    = floor_bits;
        cmd_next.win_start = window_start;
        cmd_next.win_end   = window_end;
        cmd_next.minute    = MIN_W'(now_hour) * HOUR_MINUTES + MIN_W'(now_minute);
        for (int b = 0; b < UID_MAX_BYTES; b++)
        begin
            cmd_next.mask[b*8 +: 8] = (LEN_W'(b) < cmp_len) ? 8'hFF : 8'h00;
        end
    end

    // Hold the request until the queue takes it
    assign valid_next = accept || (valid_reg && !cmd_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd_next;
        end
    end

    assign cmd_valid = valid_reg;
    assign cmd       = cmd_reg;

endmodule

/* rtl/core/carc_cmd_fifo.sv */
// Short request queue between front and back of the card access rule check
// unit. Depends on carc_pkg for the default depth.
`timescale 1ns / 1ps

module carc_cmd_fifo import carc_pkg::*; #(
    parameter int WIDTH = 1,
    parameter int DEPTH = CMD_FIFO_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  logic [WIDTH-1:0]    wr_data,
    output logic                wr_full,
    input  logic                rd_en,
    output logic [WIDTH-1:0]    rd_data,
    output logic                rd_valid
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]   store_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               do_wr;
    logic               do_rd;

    assign wr_full  = (count_reg == CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign do_wr    = wr_en && !wr_full;
    assign do_rd    = rd_en && rd_valid;
    assign rd_data  = store_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            store_reg[wr_ptr_reg] <= wr_data;
        end
    end

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("request queue count above depth");

    a_read_needs_data: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> rd_valid)
        else $error("request queue read while empty");

    a_empty_ptrs_equal: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("request queue pointers apart while empty");

endmodule

/* rtl/core/carc_back.sv */
// Back stage of the card access rule check unit: record table memory, clear,
// append and the linear scan that evaluates a card. Depends on carc_pkg.
`timescale 1ns / 1ps

module carc_back import carc_pkg::*; #(
    parameter int MAX_RECORDS = MAX_RECORDS_DEF,
    parameter int UID_BYTES   = UID_BYTES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    input  cmd_t                cmd,
    output logic                cmd_pop,
    input  logic [SEL_W-1:0]    floor_select,
    output res_t                res,
    output logic                res_valid,
    input  logic                res_pop
);

    localparam int UID_W  = 8 * UID_BYTES;
    localparam int CNT_W  = $clog2(MAX_RECORDS + 1);
    localparam int ADDR_W = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;

    typedef struct packed {
        logic [UID_W-1:0]   uid;
        logic [LEN_W-1:0]   len;
        logic [STAMP_W-1:0] expiry;
        logic [FLOOR_W-1:0] floors;
        logic [MIN_W-1:0]   win_start;
        logic [MIN_W-1:0]   win_end;
    } rec_t;

    rec_t               table_mem [MAX_RECORDS];
    rec_t               rd_data_reg;
    rec_t               wr_rec;

    bk_state_t          state_reg;
    bk_state_t          state_next;
    logic [CNT_W-1:0]   total_reg;
    logic [CNT_W-1:0]   total_next;
    logic [CNT_W-1:0]   addr_reg;
    logic [CNT_W-1:0]   addr_next;
    logic               rd_valid_reg;
    logic               rd_valid_next;
    cmd_t               cur_reg;
    cmd_t               cur_next;
    res_t               res_reg;
    res_t               res_next;
    logic               res_valid_reg;
    logic               res_valid_next;

    logic               take;
    logic               has_room;
    logic               wr_en;
    logic               issue;
    logic               match;
    logic               hit;
    logic               scan_miss;
    logic               in_window;
    verdict_t           hit_verdict;

    assign take     = (state_reg == BK_IDLE) && cmd_valid && !res_valid_reg;
    assign has_room = (total_reg < CNT_W'(MAX_RECORDS));
    assign wr_en    = take && (cmd.kind == OP_APPEND) && has_room;
    assign issue    = (state_reg == BK_SCAN) && (addr_reg < total_reg);

    assign wr_rec.uid       = cmd.uid[UID_W-1:0];
    assign wr_rec.len       = cmd.len;
    assign wr_rec.expiry    = cmd.stamp;
    assign wr_rec.floors    = cmd.floors;
    assign wr_rec.win_start = cmd.win_start;
    assign wr_rec.win_end   = cmd.win_end;

    // Compare and rule checks on the record read in the previous cycle
    assign match = (rd_data_reg.len == cur_reg.len)
                && (((rd_data_reg.uid ^ cur_reg.uid[UID_W-1:0])
                     & cur_reg.mask[UID_W-1:0]) == '0);
    assign hit       = (state_reg == BK_SCAN) && rd_valid_reg && match;
    assign scan_miss = (state_reg == BK_SCAN) && !issue && !rd_valid_reg;

    always_comb
    begin
        if (rd_data_reg.win_start <= rd_data_reg.win_end)
        begin
            in_window = (cur_reg.minute >= rd_data_reg.win_start)
                     && (cur_reg.minute <= rd_data_reg.win_end);
        end
        else
        begin
            in_window = (cur_reg.minute >= rd_data_reg.win_start)
                     || (cur_reg.minute <= rd_data_reg.win_end);
        end
    end

    always_comb
    begin
        priority if (cur_reg.stamp > rd_data_reg.expiry)
        begin
            hit_verdict = V_EXPIRED;
        end
        else if (!rd_data_reg.floors[floor_select])
        begin
            hit_verdict = V_UNKNOWN;
        end
        else if ((rd_data_reg.win_start == '0) && (rd_data_reg.win_end == DAY_MINUTES))
        begin
            hit_verdict = V_GRANTED;
        end
        else
        begin
            hit_verdict = in_window ? V_GRANTED : V_SCHEDULE;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (take && (cmd.kind == OP_EVAL) && (total_reg != '0))
                begin
                    state_next = BK_SCAN;
                end
            end
            BK_SCAN:
            begin
                if (hit || scan_miss)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        total_next     = total_reg;
        addr_next      = addr_reg;
        rd_valid_next  = 1'b0;
        cur_next       = cur_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && !res_pop;
        cmd_pop        = take;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (take)
                begin
                    cur_next  = cmd;
                    addr_next = '0;
                    res_next.verdict = V_UNKNOWN;
                    res_next.stored  = 1'b0;
                    unique case (cmd.kind)
                        OP_CLEAR:
                        begin
                            total_next     = '0;
                            res_valid_next = 1'b1;
                        end
                        OP_APPEND:
                        begin
                            if (has_room)
                            begin
                                total_next      = total_reg + 1'b1;
                                res_next.stored = 1'b1;
                            end
                            res_valid_next = 1'b1;
                        end
                        OP_EVAL:
                        begin
                            // An empty table answers at once
                            res_valid_next = (total_reg == '0);
                        end
                        default:
                        begin
                            res_valid_next = 1'b1;
                        end
                    endcase
                    res_next.count = COUNT_W'(total_next);
                end
            end
            BK_SCAN:
            begin
                if (hit)
                begin
                    res_next.verdict = hit_verdict;
                    res_next.stored  = 1'b0;
                    res_next.count   = COUNT_W'(total_reg);
                    res_valid_next   = 1'b1;
                end
                else if (scan_miss)
                begin
                    res_next.verdict = V_UNKNOWN;
                    res_next.stored  = 1'b0;
                    res_next.count   = COUNT_W'(total_reg);
                    res_valid_next   = 1'b1;
                end
                else
                begin
                    rd_valid_next = issue;
                    if (issue)
                    begin
                        addr_next = addr_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                res_valid_next = res_valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            total_reg     <= '0;
            addr_reg      <= '0;
            rd_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            total_reg     <= total_next;
            addr_reg      <= addr_next;
            rd_valid_reg  <= rd_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        res_reg <= res_next;
    end

    // Record table: one write port for appends, one registered read for the scan
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            table_mem[total_reg[ADDR_W-1:0]] <= wr_rec;
        end
        if (issue)
        begin
            rd_data_reg <= table_mem[addr_reg[ADDR_W-1:0]];
        end
    end

    assign res       = res_reg;
    assign res_valid = res_valid_reg;

    a_total_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= CNT_W'(MAX_RECORDS))
        else $error("record total above table size");

    a_scan_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_SCAN) |-> !res_valid_reg)
        else $error("scan running while a result waits");

    a_hit_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        hit |=> (state_reg == BK_IDLE) && res_valid_reg && (res_reg.verdict == $past(hit_verdict)))
        else $error("matching record did not produce its verdict");

endmodule

/* rtl/core/card_access_rule_check_unit.sv */
// Top level of the card access rule check unit: configuration register,
// front stage, request queue and back stage. Depends on carc_pkg,
// carc_front, carc_cmd_fifo and carc_back.
`timescale 1ns / 1ps

// The unit keeps a table of up to MAX_RECORDS card records and answers one
// result per request, in request order. Requests enter through a queue-like
// port (push/full) and results leave through another (empty/pop); a short
// request queue sits between the classifying front stage and the back stage
// that owns the table, so new requests are taken while a result waits to be
// popped. Clear, append and ignored opcodes, and an evaluate on an empty
// table, put their result on the result ports after the back stage has taken
// the request from the queue. An evaluate scans the table from the oldest record
// through the single read port of the table memory, one record per cycle, and
// stops at the first record whose length and UID bytes match. The back stage
// handles one request at a time. The table needs no clearing pass after reset:
// only records below the record count are ever read. floor_select is the only
// register, at byte address 0 of the APB port; it should be written only while
// the unit is idle.

module card_access_rule_check_unit import carc_pkg::*; #(
    parameter int MAX_RECORDS = MAX_RECORDS_DEF,
    parameter int UID_BYTES   = UID_BYTES_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    // Configuration port
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [CFG_ADDR_W-1:0]   paddr,
    input  logic [CFG_DATA_W-1:0]   pwdata,
    output logic [CFG_DATA_W-1:0]   prdata,
    output logic                    pready,
    // Request side
    input  logic                    push,
    output logic                    full,
    input  logic [1:0]              opcode,
    input  logic [UID_LOW_W-1:0]    uid_low,
    input  logic [UID_HIGH_W-1:0]   uid_high,
    input  logic [LEN_W-1:0]        uid_length,
    input  logic [STAMP_W-1:0]      valid_until,
    input  logic [FLOOR_W-1:0]      floor_bits,
    input  logic [MIN_W-1:0]        window_start,
    input  logic [MIN_W-1:0]        window_end,
    input  logic [STAMP_W-1:0]      now_seconds,
    input  logic [HOUR_W-1:0]       now_hour,
    input  logic [MINUTE_W-1:0]     now_minute,
    // Result side
    output logic                    empty,
    input  logic                    pop,
    output logic [1:0]              verdict,
    output logic                    stored,
    output logic [COUNT_W-1:0]      record_count
);

    logic [SEL_W-1:0]   floor_select_reg;
    logic [SEL_W-1:0]   floor_select_next;
    logic               reg_index;
    logic               cfg_write;

    logic               front_valid;
    cmd_t               front_cmd;
    logic               queue_full;
    logic               queue_valid;
    logic [$bits(cmd_t)-1:0] queue_data;
    cmd_t               queue_cmd;
    logic               queue_pop;
    res_t               res;
    logic               res_valid;

    // Configuration: register index is the word address
    assign pready    = 1'b1;
    assign reg_index = paddr[2];
    assign cfg_write = psel && penable && pwrite && pready;

    assign floor_select_next = (cfg_write && (reg_index == REG_FLOOR_SELECT))
                             ? pwdata[SEL_W-1:0] : floor_select_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            floor_select_reg <= '0;
        end
        else
        begin
            floor_select_reg <= floor_select_next;
        end
    end

    // Read back the register, zero elsewhere
    assign prdata = (reg_index == REG_FLOOR_SELECT)
                  ? CFG_DATA_W'(floor_select_reg) : '0;

    // Front: take and classify the request
    carc_front #(
        .UID_BYTES (UID_BYTES)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .opcode       (opcode),
        .uid_low      (uid_low),
        .uid_high     (uid_high),
        .uid_length   (uid_length),
        .valid_until  (valid_until),
        .floor_bits   (floor_bits),
        .window_start (window_start),
        .window_end   (window_end),
        .now_seconds  (now_seconds),
        .now_hour     (now_hour),
        .now_minute   (now_minute),
        .cmd_valid    (front_valid),
        .cmd          (front_cmd),
        .cmd_ready    (!queue_full)
    );

    // Decouple front and back
    carc_cmd_fifo #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (CMD_FIFO_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (front_valid),
        .wr_data  (front_cmd),
        .wr_full  (queue_full),
        .rd_en    (queue_pop),
        .rd_data  (queue_data),
        .rd_valid (queue_valid)
    );

    assign queue_cmd = queue_data;

    // Back: own the table, carry out the request, hold the result
    carc_back #(
        .MAX_RECORDS (MAX_RECORDS),
        .UID_BYTES   (UID_BYTES)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (queue_valid),
        .cmd          (queue_cmd),
        .cmd_pop      (queue_pop),
        .floor_select (floor_select_reg),
        .res          (res),
        .res_valid    (res_valid),
        .res_pop      (pop)
    );

    assign empty        = !res_valid;
    assign verdict      = res.verdict;
    assign stored       = res.stored;
    assign record_count = res.count;

endmodule

/* sim/card_access_rule_check_unit_tb.sv */
// Self-checking testbench for card_access_rule_check_unit: directed and random requests
// against a behavioral model of the card table. Depends on carc_pkg and the unit RTL.
`timescale 1ns / 1ps

module card_access_rule_check_unit_tb;
    import carc_pkg::*;

    localparam int TABLE_DEPTH = MAX_RECORDS_DEF;
    localparam int CMP_BYTES   = UID_BYTES_DEF;

    // One request as it is pushed into the unit
    typedef struct packed {
        op_t                    op;
        logic [UID_LOW_W-1:0]   uid_lo;
        logic [UID_HIGH_W-1:0]  uid_hi;
        logic [LEN_W-1:0]       len;
        logic [STAMP_W-1:0]     expiry;
        logic [FLOOR_W-1:0]     floors;
        logic [MIN_W-1:0]       win_start;
        logic [MIN_W-1:0]       win_end;
        logic [STAMP_W-1:0]     now;
        logic [HOUR_W-1:0]      hour;
        logic [MINUTE_W-1:0]    minute;
    } card_req_t;

    // Card table tracker: holds its own copy of the record table and the floor
    // selection, works out the answer to every accepted request and checks the
    // unit's answers in order.
    class card_table_tracker;
        logic [UID_MAX_W-1:0]   t_uid    [TABLE_DEPTH];
        logic [LEN_W-1:0]       t_len    [TABLE_DEPTH];
        logic [STAMP_W-1:0]     t_expiry [TABLE_DEPTH];
        logic [FLOOR_W-1:0]     t_floors [TABLE_DEPTH];
        logic [MIN_W-1:0]       t_start  [TABLE_DEPTH];
        logic [MIN_W-1:0]       t_end    [TABLE_DEPTH];
        int                     total;
        logic [SEL_W-1:0]       floor_sel;
        res_t                   pending_answers [$];
        int                     errors;
        int                     requests;
        int                     answers;
        int                     drops;
        int                     clears;
        int                     tally [4];

        function new();
            total     = 0;
            floor_sel = '0;
            errors    = 0;
            requests  = 0;
            answers   = 0;
            drops     = 0;
            clears    = 0;
            foreach (tally[k])
                tally[k] = 0;
        endfunction

        function int waiting();
            return pending_answers.size();
        endfunction

        // First record with equal length and equal compared bytes decides.
        function verdict_t look_up(card_req_t r);
            logic [UID_MAX_W-1:0] key;
            logic [UID_MAX_W-1:0] mask;
            int                   n;
            int                   minute;
            int                   s;
            int                   e;
            bit                   in_window;
            key    = {r.uid_hi, r.uid_lo};
            mask   = '0;
            n      = (int'(r.len) > CMP_BYTES) ? CMP_BYTES : int'(r.len);
            minute = 60 * int'(r.hour) + int'(r.minute);
            for (int b = 0; b < n; b++)
                mask[8*b +: 8] = 8'hFF;
            for (int i = 0; i < total; i++)
            begin
                if (t_len[i] != r.len)
                    continue;
                if (((t_uid[i] ^ key) & mask) != '0)
                    continue;
                if (r.now > t_expiry[i])
                    return V_EXPIRED;
                if (!t_floors[i][floor_sel])
                    return V_UNKNOWN;
                s = int'(t_start[i]);
                e = int'(t_end[i]);
                if (s == 0 && e == int'(DAY_MINUTES))
                    return V_GRANTED;
                if (s <= e)
                    in_window = (minute >= s) && (minute <= e);
                else
                    in_window = (minute >= s) || (minute <= e);
                return in_window ? V_GRANTED : V_SCHEDULE;
            end
            return V_UNKNOWN;
        endfunction

        function void take_request(card_req_t r);
            res_t a;
            a.verdict = V_UNKNOWN;
            a.stored  = 1'b0;
            requests++;
            case (r.op)
                OP_CLEAR:
                begin
                    total = 0;
                    clears++;
                end
                OP_APPEND:
                begin
                    if (total < TABLE_DEPTH)
                    begin
                        t_uid[total]    = {r.uid_hi, r.uid_lo};
                        t_len[total]    = r.len;
                        t_expiry[total] = r.expiry;
                        t_floors[total] = r.floors;
                        t_start[total]  = r.win_start;
                        t_end[total]    = r.win_end;
                        total++;
                        a.stored = 1'b1;
                    end
                    else
                        drops++;
                end
                OP_EVAL:
                begin
                    a.verdict = look_up(r);
                    tally[a.verdict]++;
                end
                default: ;
            endcase
            a.count = COUNT_W'(total);
            pending_answers.insert(pending_answers.size(), a);
        endfunction

        function void match_result(logic [1:0] v, logic s, logic [COUNT_W-1:0] c);
            res_t a;
            answers++;
            if (pending_answers.size() == 0)
            begin
                $display("%0t: result with no request waiting (verdict %0d stored %0d count %0d)",
                         $time, v, s, c);
                errors++;
                return;
            end
            a = pending_answers.pop_front();
            if (v !== a.verdict)
            begin
                $display("%0t: verdict mismatch, expected %0d actual %0d", $time, a.verdict, v);
                errors++;
            end
            if (s !== a.stored)
            begin
                $display("%0t: stored mismatch, expected %0d actual %0d", $time, a.stored, s);
                errors++;
            end
            if (c !== a.count)
            begin
                $display("%0t: record_count mismatch, expected %0d actual %0d",
                         $time, a.count, c);
                errors++;
            end
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0]  paddr = '0;
    logic [CFG_DATA_W-1:0]  pwdata = '0;
    logic [CFG_DATA_W-1:0]  prdata;
    logic                   pready;
    logic                   push = 1'b0;
    logic                   full;
    logic [1:0]             opcode = OP_CLEAR;
    logic [UID_LOW_W-1:0]   uid_low = '0;
    logic [UID_HIGH_W-1:0]  uid_high = '0;
    logic [LEN_W-1:0]       uid_length = '0;
    logic [STAMP_W-1:0]     valid_until = '0;
    logic [FLOOR_W-1:0]     floor_bits = '0;
    logic [MIN_W-1:0]       window_start = '0;
    logic [MIN_W-1:0]       window_end = '0;
    logic [STAMP_W-1:0]     now_seconds = '0;
    logic [HOUR_W-1:0]      now_hour = '0;
    logic [MINUTE_W-1:0]    now_minute = '0;
    logic                   empty;
    logic                   pop = 1'b0;
    logic [1:0]             verdict;
    logic                   stored;
    logic [COUNT_W-1:0]     record_count;

    card_table_tracker tracker = new();

    // Percent of cycles in which each side holds off
    int push_idle_pct = 28;
    int pop_idle_pct  = 61;

    // A small set of known cards, so that most scans hit a stored record
    logic [UID_LOW_W-1:0]   pool_lo  [16];
    logic [UID_HIGH_W-1:0]  pool_hi  [16];
    logic [LEN_W-1:0]       pool_len [16];

    card_access_rule_check_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .push         (push),
        .full         (full),
        .opcode       (opcode),
        .uid_low      (uid_low),
        .uid_high     (uid_high),
        .uid_length   (uid_length),
        .valid_until  (valid_until),
        .floor_bits   (floor_bits),
        .window_start (window_start),
        .window_end   (window_end),
        .now_seconds  (now_seconds),
        .now_hour     (now_hour),
        .now_minute   (now_minute),
        .empty        (empty),
        .pop          (pop),
        .verdict      (verdict),
        .stored       (stored),
        .record_count (record_count)
    );

    always #2 clk = ~clk;

    // Result side: check every popped result against the oldest answer, and
    // pick the next cycle's pop at random according to the current idle rate.
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
            tracker.match_result(verdict, stored, record_count);
        pop <= ($urandom_range(99) >= pop_idle_pct);
    end

    // Hard stop in case the unit hangs
    initial
    begin
        #15_000_000;
        $display("FAIL card_access_rule_check_unit");
        $finish;
    end

    function automatic card_req_t req(op_t op, logic [UID_LOW_W-1:0] lo,
                                      logic [UID_HIGH_W-1:0] hi, logic [LEN_W-1:0] len,
                                      logic [STAMP_W-1:0] expiry, logic [FLOOR_W-1:0] floors,
                                      logic [MIN_W-1:0] ws, logic [MIN_W-1:0] we,
                                      logic [STAMP_W-1:0] now, logic [HOUR_W-1:0] hr,
                                      logic [MINUTE_W-1:0] mn);
        card_req_t r;
        r.op        = op;
        r.uid_lo    = lo;
        r.uid_hi    = hi;
        r.len       = len;
        r.expiry    = expiry;
        r.floors    = floors;
        r.win_start = ws;
        r.win_end   = we;
        r.now       = now;
        r.hour      = hr;
        r.minute    = mn;
        return r;
    endfunction

    // Start from all-random fields; each opcode then overwrites the ones it uses.
    function automatic card_req_t noise_request(op_t op);
        return req(op, {$urandom, $urandom}, UID_HIGH_W'($urandom), LEN_W'($urandom),
                   $urandom, $urandom, MIN_W'($urandom), MIN_W'($urandom),
                   $urandom, HOUR_W'($urandom), MINUTE_W'($urandom));
    endfunction

    // Stamps cluster around a few values so that equal, just-before and
    // just-after expiry all come up.
    function automatic logic [STAMP_W-1:0] pick_stamp();
        case ($urandom_range(5))
            0: return '0;
            1: return '1;
            2: return 32'd999;
            3: return 32'd1000;
            4: return 32'd1001;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [LEN_W-1:0] pick_length();
        if ($urandom_range(9) < 8)
            return LEN_W'($urandom_range(1, 10));
        return LEN_W'($urandom_range(15));
    endfunction

    // Take a known card, or a random one, and scramble the bytes past its length.
    function automatic void pick_uid(int known_pct, output logic [UID_LOW_W-1:0] lo,
                                     output logic [UID_HIGH_W-1:0] hi,
                                     output logic [LEN_W-1:0] len);
        logic [UID_MAX_W-1:0] uid;
        logic [UID_MAX_W-1:0] mask;
        logic [UID_MAX_W-1:0] junk;
        int                   k;
        int                   n;
        if ($urandom_range(99) < known_pct)
        begin
            k   = $urandom_range(15);
            uid = {pool_hi[k], pool_lo[k]};
            len = pool_len[k];
        end
        else
        begin
            uid = {UID_HIGH_W'($urandom), $urandom, $urandom};
            len = pick_length();
        end
        junk = {UID_HIGH_W'($urandom), $urandom, $urandom};
        mask = '0;
        n    = (int'(len) > CMP_BYTES) ? CMP_BYTES : int'(len);
        for (int b = 0; b < n; b++)
            mask[8*b +: 8] = 8'hFF;
        uid = (uid & mask) | (junk & ~mask);
        hi  = uid[UID_MAX_W-1:UID_LOW_W];
        lo  = uid[UID_LOW_W-1:0];
    endfunction

    function automatic card_req_t append_request();
        card_req_t r;
        r = noise_request(OP_APPEND);
        pick_uid(75, r.uid_lo, r.uid_hi, r.len);
        r.expiry = pick_stamp();
        case ($urandom_range(9))
            0: r.floors = '0;
            1: r.floors = '1;
            default: r.floors = $urandom;
        endcase
        case ($urandom_range(19))
            0, 1, 2, 3, 4, 5, 6:
            begin
                r.win_start = '0;
                r.win_end   = DAY_MINUTES;
            end
            7, 8:
            begin
                r.win_start = MIN_W'($urandom);
                r.win_end   = MIN_W'($urandom);
            end
            9:
            begin
                r.win_start = MIN_W'($urandom_range(1440));
                r.win_end   = r.win_start;
            end
            default:
            begin
                r.win_start = MIN_W'($urandom_range(1440));
                r.win_end   = MIN_W'($urandom_range(1440));
            end
        endcase
        return r;
    endfunction

    function automatic card_req_t scan_request();
        card_req_t r;
        r = noise_request(OP_EVAL);
        pick_uid(80, r.uid_lo, r.uid_hi, r.len);
        r.now = pick_stamp();
        if ($urandom_range(99) < 85)
        begin
            r.hour   = HOUR_W'($urandom_range(23));
            r.minute = MINUTE_W'($urandom_range(59));
        end
        return r;
    endfunction

    // Mostly appends and scans; clears at the given rate per thousand, plus
    // a few ignored opcodes.
    function automatic card_req_t random_request(int clear_permille);
        int roll;
        roll = $urandom_range(999);
        if (roll < clear_permille)
            return noise_request(OP_CLEAR);
        if (roll < clear_permille + 30)
            return noise_request(OP_NONE);
        if (roll < 450)
            return append_request();
        return scan_request();
    endfunction

    // Push one request: hold off at random first, then keep push high until
    // the unit takes it. push stays high on return so that back-to-back
    // requests never lower and raise it in the same step.
    task automatic send(input card_req_t r);
        while ($urandom_range(99) < push_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push         <= 1'b1;
        opcode       <= r.op;
        uid_low      <= r.uid_lo;
        uid_high     <= r.uid_hi;
        uid_length   <= r.len;
        valid_until  <= r.expiry;
        floor_bits   <= r.floors;
        window_start <= r.win_start;
        window_end   <= r.win_end;
        now_seconds  <= r.now;
        now_hour     <= r.hour;
        now_minute   <= r.minute;
        @(posedge clk);
        while (full)
            @(posedge clk);
        tracker.take_request(r);
    endtask

    // Drop push and hold until every pending answer has been popped.
    task automatic drain();
        push <= 1'b0;
        while (tracker.waiting() != 0)
            @(posedge clk);
    endtask

    // APB write of floor_select: setup cycle, then access cycle.
    task automatic write_floor_select(input logic [SEL_W-1:0] sel);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_W'(4 * int'(REG_FLOOR_SELECT));
        pwdata  <= CFG_DATA_W'(sel);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tracker.floor_sel = sel;
    endtask

    // Short directed pass, run with floor_select 0: empty table, full-day and
    // plain windows, expiry edges, floor bit clear, long and zero lengths,
    // midnight-crossing windows, first match wins, clear, ignored opcode.
    task automatic run_directed();
        logic [UID_LOW_W-1:0] d_lo;
        d_lo = 64'h0123_4567_89AB_CDEF;
        send(req(OP_EVAL, '1, '1, 4'd10, '0, '0, '0, '0, 32'd5, 5'd1, 6'd2));
        send(req(OP_NONE, '1, '1, '1, '1, '1, '1, '1, '1, '1, '1));
        send(req(OP_APPEND, '1, '1, 4'd10, '1, '1, '0, DAY_MINUTES, '0, '0, '0));
        send(req(OP_EVAL, '1, '1, 4'd10, '0, '0, '0, '0, '0, 5'd0, 6'd0));
        send(req(OP_EVAL, '1, '1, 4'd10, '0, '0, '0, '0, '1, 5'd23, 6'd59));
        send(req(OP_APPEND, 64'hDEAD_BEEF_1122_3344, 16'hAAAA, 4'd4, 32'd1000, 32'h1,
                 11'd600, 11'd1020, '0, '0, '0));
        send(req(OP_EVAL, 64'h0BAD_F00D_1122_3344, 16'h5555, 4'd4, '0, '0, '0, '0,
                 32'd1001, 5'd10, 6'd0));
        send(req(OP_EVAL, 64'h0000_0000_1122_3344, 16'h0000, 4'd4, '0, '0, '0, '0,
                 32'd1000, 5'd10, 6'd0));
        send(req(OP_EVAL, 64'hFFFF_FFFF_1122_3344, 16'h1234, 4'd4, '0, '0, '0, '0,
                 32'd10, 5'd17, 6'd1));
        send(req(OP_EVAL, 64'h1122_3344, '0, 4'd4, '0, '0, '0, '0, 32'd10, 5'd9, 6'd59));
        send(req(OP_APPEND, 64'hABCDEF, '0, 4'd3, '1, 32'h8000_0000, 11'd1320, 11'd360,
                 '0, '0, '0));
        send(req(OP_EVAL, 64'hABCDEF, '0, 4'd3, '0, '0, '0, '0, '0, 5'd12, 6'd0));
        send(req(OP_APPEND, d_lo, 16'h5A5A, 4'd12, '1, '1, 11'd1320, 11'd360, '0, '0, '0));
        send(req(OP_EVAL, d_lo, 16'h5A5A, 4'd12, '0, '0, '0, '0, '0, 5'd23, 6'd0));
        send(req(OP_EVAL, d_lo, 16'h5A5A, 4'd12, '0, '0, '0, '0, '0, 5'd12, 6'd0));
        send(req(OP_EVAL, d_lo, 16'h5A5A, 4'd12, '0, '0, '0, '0, '0, 5'd6, 6'd0));
        send(req(OP_EVAL, d_lo, 16'h5A5A, 4'd10, '0, '0, '0, '0, '0, 5'd23, 6'd0));
        send(req(OP_APPEND, 64'h7777, '0, 4'd0, '1, '1, '0, '0, '0, '0, '0));
        send(req(OP_EVAL, {$urandom, $urandom}, '1, 4'd0, '0, '0, '0, '0, '0, 5'd0, 6'd0));
        send(req(OP_EVAL, '0, '0, 4'd0, '0, '0, '0, '0, '0, 5'd31, 6'd63));
        send(req(OP_APPEND, 64'h1122_3344, '0, 4'd4, '1, '1, '0, DAY_MINUTES, '0, '0, '0));
        send(req(OP_EVAL, 64'h1122_3344, '0, 4'd4, '0, '0, '0, '0, 32'd2000, 5'd12, 6'd0));
        send(req(OP_CLEAR, '1, '1, '1, '1, '1, '1, '1, '1, '1, '1));
        send(req(OP_EVAL, '1, '1, 4'd10, '0, '0, '0, '0, '0, 5'd0, 6'd0));
        send(req(OP_APPEND, 64'h55, '0, 4'd1, '1, '1, 11'd2047, DAY_MINUTES, '0, '0, '0));
        send(req(OP_EVAL, 64'h55, '0, 4'd1, '0, '0, '0, '0, '0, 5'd31, 6'd63));
    endtask

    initial
    begin
        for (int k = 0; k < 16; k++)
        begin
            pool_lo[k]  = {$urandom, $urandom};
            pool_hi[k]  = UID_HIGH_W'($urandom);
            pool_len[k] = pick_length();
        end
        // The pool must hold the length corners too
        pool_len[0] = 4'd0;
        pool_len[1] = 4'd10;
        pool_len[2] = 4'd15;
        pool_len[3] = 4'd8;
        pool_len[4] = 4'd9;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Phase 1: sender idles 28 percent, receiver 61 percent.
        write_floor_select('0);
        run_directed();
        drain();
        write_floor_select('1);
        for (int n = 0; n < 600; n++)
            send(random_request(15));

        // Phase 2: rates swapped. Clear, then append past the table size so
        // that appends to a full table get dropped, then scan a full table.
        drain();
        push_idle_pct = 61;
        pop_idle_pct  = 28;
        write_floor_select(SEL_W'($urandom_range(1, 30)));
        send(noise_request(OP_CLEAR));
        for (int n = 0; n < TABLE_DEPTH + 14; n++)
            send(append_request());
        for (int n = 0; n < 330; n++)
            send(random_request(2));

        // Phase 3: no idling on either side. The sender pauses here until
        // every pending answer has come back before the register changes.
        drain();
        push_idle_pct = 0;
        pop_idle_pct  = 0;
        write_floor_select(SEL_W'($urandom));
        for (int n = 0; n < 620; n++)
            send(random_request(15));

        drain();
        // Allow for a worst-case table scan in case a stray result is on its way
        repeat (TABLE_DEPTH + 8) @(posedge clk);

        $display("Covered %0d requests (%0d clears, %0d appends dropped on a full table).",
                 tracker.requests, tracker.clears, tracker.drops);
        $display("Scan verdicts: %0d granted, %0d schedule, %0d expired, %0d unknown.",
                 tracker.tally[V_GRANTED], tracker.tally[V_SCHEDULE],
                 tracker.tally[V_EXPIRED], tracker.tally[V_UNKNOWN]);
        if (tracker.errors == 0 && tracker.waiting() == 0)
            $display("PASS card_access_rule_check_unit");
        else
            $display("FAIL card_access_rule_check_unit");
        $finish;
    end

endmodule
